>>> hdl/assert_macros.svh
// assertion helpers, empty when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: invariant");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> hdl/tkst_pkg.sv
package tkst_pkg;

   // default sizes
   localparam int TABLE_DEPTH_DEF = 8;
   localparam int NAME_CHARS_DEF  = 8;

   // fixed field widths
   localparam int SCORE_W = 32;
   localparam int NAME_W  = 64;
   localparam int LEN_W   = 4;
   localparam int RIDX_W  = 3;
   localparam int RANK_W  = 3;
   localparam int FILL_W  = 4;

   typedef enum logic [1:0] {
      OP_QUALIFY = 2'd0,
      OP_INSERT  = 2'd1,
      OP_CLEAR   = 2'd2,
      OP_READ    = 2'd3
   } opcode_type;

   // controller to table commands
   typedef struct packed {
      logic ld_en;    // capture incoming entry
      logic rd_en;    // read slot at rd_addr
      logic wr_en;    // write slot at wr_addr
      logic wr_new;   // write captured entry, else move read data down
      logic held_clr; // empty the table
      logic held_inc; // one more entry, saturating at depth
   } tbl_ctrl_type;

endpackage

>>> hdl/tkst_req_if.sv
interface tkst_req_if;
   import tkst_pkg::*;

   logic                valid;
   logic                ready;
   opcode_type          opcode;
   logic [SCORE_W-1:0]  score;
   logic [NAME_W-1:0]   player_name;
   logic [LEN_W-1:0]    name_len;
   logic [RIDX_W-1:0]   read_index;

   modport source (
      output valid, opcode, score, player_name, name_len, read_index,
      input  ready
   );

   modport sink (
      input  valid, opcode, score, player_name, name_len, read_index,
      output ready
   );

endinterface

>>> hdl/tkst_rsp_if.sv
interface tkst_rsp_if;
   import tkst_pkg::*;

   logic                valid;
   logic                ready;
   logic                placed;
   logic [RANK_W-1:0]   rank;
   logic                entry_valid;
   logic [SCORE_W-1:0]  entry_score;
   logic [NAME_W-1:0]   entry_name;
   logic [LEN_W-1:0]    entry_name_len;
   logic [FILL_W-1:0]   fill_count;

   modport source (
      output valid, placed, rank, entry_valid, entry_score, entry_name,
             entry_name_len, fill_count,
      input  ready
   );

   modport sink (
      input  valid, placed, rank, entry_valid, entry_score, entry_name,
             entry_name_len, fill_count,
      output ready
   );

endinterface

>>> hdl/tkst_table.sv
`include "assert_macros.svh"

module tkst_table #(
   parameter int TABLE_DEPTH = tkst_pkg::TABLE_DEPTH_DEF,
   parameter int NAME_CHARS  = tkst_pkg::NAME_CHARS_DEF,
   localparam int IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
   localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tkst_pkg::tbl_ctrl_type        tbl_ctrl,
   input  logic [IDX_W-1:0]              rd_addr,
   input  logic [IDX_W-1:0]              wr_addr,
   input  logic [tkst_pkg::SCORE_W-1:0]  ld_score,
   input  logic [tkst_pkg::NAME_W-1:0]   ld_name,
   input  logic [tkst_pkg::LEN_W-1:0]    ld_len,
   output logic [CNT_W-1:0]              held,
   output logic [tkst_pkg::SCORE_W-1:0]  stg_score,
   output logic [tkst_pkg::SCORE_W-1:0]  rd_score,
   output logic [tkst_pkg::NAME_W-1:0]   rd_name,
   output logic [tkst_pkg::LEN_W-1:0]    rd_len
);
   import tkst_pkg::*;

   localparam int NAME_BITS = NAME_CHARS * 8;

   logic [SCORE_W-1:0]   score_mem [TABLE_DEPTH];
   logic [NAME_BITS-1:0] name_mem  [TABLE_DEPTH];
   logic [LEN_W-1:0]     len_mem   [TABLE_DEPTH];

   logic [SCORE_W-1:0]   rd_score_ff;
   logic [NAME_BITS-1:0] rd_name_ff;
   logic [LEN_W-1:0]     rd_len_ff;

   logic [SCORE_W-1:0]   stg_score_ff;
   logic [NAME_BITS-1:0] stg_name_ff;
   logic [LEN_W-1:0]     stg_len_ff;

   logic [LEN_W-1:0]     len_sat;
   logic [NAME_BITS-1:0] name_msk;

   logic [CNT_W-1:0]     held_ff;
   logic [CNT_W-1:0]     held_in;

   // saturate length, zero bytes past it
   always_comb begin
      len_sat = (ld_len > LEN_W'(NAME_CHARS)) ? LEN_W'(NAME_CHARS) : ld_len;
      for (int b = 0; b < NAME_CHARS; b++) begin
         name_msk[b*8 +: 8] = (LEN_W'(b) < len_sat) ? ld_name[b*8 +: 8] : 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_ctrl.ld_en) begin
         stg_score_ff <= ld_score;
         stg_name_ff  <= name_msk;
         stg_len_ff   <= len_sat;
      end
      if (tbl_ctrl.wr_en) begin
         score_mem[wr_addr] <= tbl_ctrl.wr_new ? stg_score_ff : rd_score_ff;
         name_mem[wr_addr]  <= tbl_ctrl.wr_new ? stg_name_ff  : rd_name_ff;
         len_mem[wr_addr]   <= tbl_ctrl.wr_new ? stg_len_ff   : rd_len_ff;
      end
      if (tbl_ctrl.rd_en) begin
         rd_score_ff <= score_mem[rd_addr];
         rd_name_ff  <= name_mem[rd_addr];
         rd_len_ff   <= len_mem[rd_addr];
      end
   end

   always_comb begin
      held_in = held_ff;
      if (tbl_ctrl.held_clr) begin
         held_in = '0;
      end else if (tbl_ctrl.held_inc && (held_ff != CNT_W'(TABLE_DEPTH))) begin
         held_in = held_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

   assign held      = held_ff;
   assign stg_score = stg_score_ff;
   assign rd_score  = rd_score_ff;
   assign rd_name   = NAME_W'(rd_name_ff);
   assign rd_len    = rd_len_ff;

   `ASSERT_ALWAYS(a_held_bound, clock, reset, held_ff <= CNT_W'(TABLE_DEPTH))
   `ASSERT_NEXT(a_held_clear, clock, reset, tbl_ctrl.held_clr, held_ff == '0)
   `ASSERT_NEXT(a_held_grow, clock, reset, tbl_ctrl.held_inc && !tbl_ctrl.held_clr && held_ff != CNT_W'(TABLE_DEPTH), held_ff == $past(held_ff) + 1'b1)

endmodule

>>> hdl/tkst_ctrl.sv
`include "assert_macros.svh"

module tkst_ctrl #(
   parameter int TABLE_DEPTH = tkst_pkg::TABLE_DEPTH_DEF,
   localparam int IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
   localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   tkst_req_if.sink                      req_ch,
   tkst_rsp_if.source                    rsp_ch,
   output tkst_pkg::tbl_ctrl_type        tbl_ctrl,
   output logic [IDX_W-1:0]              rd_addr,
   output logic [IDX_W-1:0]              wr_addr,
   input  logic [CNT_W-1:0]              held,
   input  logic [tkst_pkg::SCORE_W-1:0]  stg_score,
   input  logic [tkst_pkg::SCORE_W-1:0]  rd_score,
   input  logic [tkst_pkg::NAME_W-1:0]   rd_name,
   input  logic [tkst_pkg::LEN_W-1:0]    rd_len
);
   import tkst_pkg::*;

   localparam int CW = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   opcode_type         op_ff, op_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   pos_ff, pos_in;
   logic               ridx_ok_ff, ridx_ok_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_placed_ff, rsp_placed_in;
   logic [RANK_W-1:0]  rsp_rank_ff, rsp_rank_in;
   logic               rsp_evalid_ff, rsp_evalid_in;
   logic [SCORE_W-1:0] rsp_escore_ff, rsp_escore_in;
   logic [NAME_W-1:0]  rsp_ename_ff, rsp_ename_in;
   logic [LEN_W-1:0]   rsp_elen_ff, rsp_elen_in;
   logic [FILL_W-1:0]  rsp_fill_ff, rsp_fill_in;

   logic               accept;
   logic               out_free;
   logic               score_gt;
   logic               hit;
   logic [CNT_W-1:0]   idx_next;
   logic [IDX_W-1:0]   held_last;
   logic [CNT_W-1:0]   held_after;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // the one shared comparator: captured score against the slot just read
   assign score_gt   = stg_score > rd_score;
   assign hit        = pos_ff != CNT_W'(TABLE_DEPTH);
   assign idx_next   = CNT_W'(idx_ff) + 1'b1;
   assign held_last  = IDX_W'(held - 1'b1);
   assign held_after = (hit && (held != CNT_W'(TABLE_DEPTH))) ? held + 1'b1 : held;

   always_comb begin
      tbl_ctrl      = '0;
      rd_addr       = '0;
      wr_addr       = '0;
      state_in      = state_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      ridx_ok_in    = ridx_ok_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_placed_in = rsp_placed_ff;
      rsp_rank_in   = rsp_rank_ff;
      rsp_evalid_in = rsp_evalid_ff;
      rsp_escore_in = rsp_escore_ff;
      rsp_ename_in  = rsp_ename_ff;
      rsp_elen_in   = rsp_elen_ff;
      rsp_fill_in   = rsp_fill_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in = req_ch.opcode;
               unique case (req_ch.opcode)
                  OP_QUALIFY, OP_INSERT: begin
                     tbl_ctrl.ld_en = 1'b1;
                     if ((req_ch.opcode == OP_INSERT) && (req_ch.name_len == '0)) begin
                        // empty name, refused
                        pos_in   = CNT_W'(TABLE_DEPTH);
                        state_in = ST_DONE;
                     end else if (held == '0) begin
                        pos_in   = '0;
                        state_in = ST_DONE;
                     end else begin
                        tbl_ctrl.rd_en = 1'b1;
                        rd_addr        = held_last;
                        idx_in         = held_last;
                        state_in       = ST_SCAN;
                     end
                  end
                  OP_CLEAR: begin
                     state_in = ST_DONE;
                  end
                  OP_READ: begin
                     tbl_ctrl.rd_en = 1'b1;
                     rd_addr        = IDX_W'(req_ch.read_index);
                     ridx_ok_in     = CW'(req_ch.read_index) < CW'(held);
                     state_in       = ST_DONE;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // walk from the last entry upward, on insert moving beaten entries down
            if (score_gt) begin
               if ((op_ff == OP_INSERT) && (idx_next != CNT_W'(TABLE_DEPTH))) begin
                  tbl_ctrl.wr_en = 1'b1;
                  wr_addr        = IDX_W'(idx_next);
               end
               if (idx_ff == '0) begin
                  pos_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  tbl_ctrl.rd_en = 1'b1;
                  rd_addr        = idx_ff - 1'b1;
                  idx_in         = idx_ff - 1'b1;
               end
            end else begin
               pos_in   = idx_next;
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_placed_in = 1'b0;
               rsp_rank_in   = '0;
               rsp_evalid_in = 1'b0;
               rsp_escore_in = '0;
               rsp_ename_in  = '0;
               rsp_elen_in   = '0;
               rsp_fill_in   = FILL_W'(held);
               state_in      = ST_IDLE;
               unique case (op_ff)
                  OP_QUALIFY: begin
                     rsp_placed_in = hit;
                     rsp_rank_in   = hit ? RANK_W'(pos_ff) : '0;
                  end
                  OP_INSERT: begin
                     rsp_placed_in = hit;
                     rsp_rank_in   = hit ? RANK_W'(pos_ff) : '0;
                     rsp_fill_in   = FILL_W'(held_after);
                     if (hit) begin
                        tbl_ctrl.wr_en    = 1'b1;
                        tbl_ctrl.wr_new   = 1'b1;
                        tbl_ctrl.held_inc = 1'b1;
                        wr_addr           = IDX_W'(pos_ff);
                     end
                  end
                  OP_CLEAR: begin
                     tbl_ctrl.held_clr = 1'b1;
                     rsp_fill_in       = '0;
                  end
                  OP_READ: begin
                     rsp_evalid_in = ridx_ok_ff;
                     if (ridx_ok_ff) begin
                        rsp_escore_in = rd_score;
                        rsp_ename_in  = rd_name;
                        rsp_elen_in   = rd_len;
                     end
                  end
               endcase
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      ridx_ok_ff    <= ridx_ok_in;
      rsp_placed_ff <= rsp_placed_in;
      rsp_rank_ff   <= rsp_rank_in;
      rsp_evalid_ff <= rsp_evalid_in;
      rsp_escore_ff <= rsp_escore_in;
      rsp_ename_ff  <= rsp_ename_in;
      rsp_elen_ff   <= rsp_elen_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.placed         = rsp_placed_ff;
   assign rsp_ch.rank           = rsp_rank_ff;
   assign rsp_ch.entry_valid    = rsp_evalid_ff;
   assign rsp_ch.entry_score    = rsp_escore_ff;
   assign rsp_ch.entry_name     = rsp_ename_ff;
   assign rsp_ch.entry_name_len = rsp_elen_ff;
   assign rsp_ch.fill_count     = rsp_fill_ff;

   `ASSERT_IMPLY(a_shift_in_scan, clock, reset, tbl_ctrl.wr_en && !tbl_ctrl.wr_new,
      state_ff == ST_SCAN && op_ff == OP_INSERT)
   `ASSERT_IMPLY(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff == ST_DONE))
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, state_ff != ST_IDLE)

endmodule

>>> hdl/top_k_sorted_score_table.sv
// channel   dir  payload
// req_ch    in   opcode, score, player_name, name_len, read_index
// rsp_ch    out  placed, rank, entry_valid, entry_score, entry_name, entry_name_len, fill_count
//
// clear, read and a refused empty-name insert go from the transfer straight to the result step
// qualify and insert first compare k slots (1 to TABLE_DEPTH, 0 if empty), then give the result
// the walk uses the single score comparator on the table's one read port,
// a slot a cycle
// reset is synchronous and empties the table; slot contents are not cleared
// a result waiting on rsp_ch holds the sequencer in its last step, req_ch.ready stays low
module top_k_sorted_score_table #(
   parameter int TABLE_DEPTH = tkst_pkg::TABLE_DEPTH_DEF,
   parameter int NAME_CHARS  = tkst_pkg::NAME_CHARS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   tkst_req_if.sink    req_ch,
   tkst_rsp_if.source  rsp_ch
);
   import tkst_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   // sequencer to table commands
   tbl_ctrl_type        tbl_ctrl;
   logic [IDX_W-1:0]    rd_addr;
   logic [IDX_W-1:0]    wr_addr;

   // table state seen by the sequencer
   logic [CNT_W-1:0]    held;
   logic [SCORE_W-1:0]  stg_score;
   logic [SCORE_W-1:0]  rd_score;
   logic [NAME_W-1:0]   rd_name;
   logic [LEN_W-1:0]    rd_len;

   // sequencer: compare walk, shift control, result register
   tkst_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .tbl_ctrl  (tbl_ctrl),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .held      (held),
      .stg_score (stg_score),
      .rd_score  (rd_score),
      .rd_name   (rd_name),
      .rd_len    (rd_len)
   );

   // slot memory, fill count and the captured entry of the current transfer
   tkst_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .NAME_CHARS  (NAME_CHARS)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .tbl_ctrl  (tbl_ctrl),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .ld_score  (req_ch.score),
      .ld_name   (req_ch.player_name),
      .ld_len    (req_ch.name_len),
      .held      (held),
      .stg_score (stg_score),
      .rd_score  (rd_score),
      .rd_name   (rd_name),
      .rd_len    (rd_len)
   );

endmodule
